// File: sv/kal_pkg.sv
package kal_pkg;

    // default list depth
    localparam int DEPTH_DEF = 128;

    // field widths
    localparam int CMD_W     = 2;
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 32;
    localparam int POS_W     = 8;
    localparam int STATUS_W  = 3;
    localparam int CNT_OUT_W = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd4;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
    localparam logic [OP_W-1:0] OP_APPEND    = 4'd2;
    localparam logic [OP_W-1:0] OP_SCAN_INIT = 4'd3;
    localparam logic [OP_W-1:0] OP_SCAN      = 4'd4;
    localparam logic [OP_W-1:0] OP_DEL_INIT  = 4'd5;
    localparam logic [OP_W-1:0] OP_DEL       = 4'd6;
    localparam logic [OP_W-1:0] OP_INS_INIT  = 4'd7;
    localparam logic [OP_W-1:0] OP_INS       = 4'd8;
    localparam logic [OP_W-1:0] OP_PUT       = 4'd9;
    localparam logic [OP_W-1:0] OP_RESULT    = 4'd10;

    // controller to datapath
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [STATUS_W-1:0] res_status;
        logic                res_found;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             bad_pos;
        logic             hit;
        logic             fwd_done;
        logic             rev_done;
        logic             out_free;
    } t_dp_sts;

endpackage

// File: sv/kal_ctrl.sv
module kal_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output kal_pkg::t_dp_cmd o_dp_cmd,
    input  kal_pkg::t_dp_sts i_dp_sts
);
    import kal_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_DEL_INIT = 3'd3;
    localparam logic [2:0] S_DEL      = 3'd4;
    localparam logic [2:0] S_INS      = 3'd5;
    localparam logic [2:0] S_PUT      = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [STATUS_W-1:0] r_res, n_res;
    logic                r_found, n_found;
    t_dp_cmd             dp_cmd;

    // next state and datapath command
    always_comb begin
        n_state           = r_state;
        n_res             = r_res;
        n_found           = r_found;
        dp_cmd.op         = OP_NOP;
        dp_cmd.res_status = r_res;
        dp_cmd.res_found  = r_found;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    dp_cmd.op = OP_LOAD;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_found = 1'b0;
                n_res   = ST_OK;
                case (i_dp_sts.cmd)
                    CMD_APPEND: begin
                        if (i_dp_sts.full) begin
                            n_res = ST_FULL;
                        end else begin
                            dp_cmd.op = OP_APPEND;
                        end
                        n_state = S_FINISH;
                    end
                    CMD_SEARCH, CMD_DELETE: begin
                        if (i_dp_sts.empty) begin
                            n_res   = ST_EMPTY;
                            n_state = S_FINISH;
                        end else begin
                            dp_cmd.op = OP_SCAN_INIT;
                            n_state   = S_SCAN;
                        end
                    end
                    CMD_INSERT: begin
                        if (i_dp_sts.full) begin
                            n_res   = ST_FULL;
                            n_state = S_FINISH;
                        end else if (i_dp_sts.bad_pos) begin
                            n_res   = ST_BADPOS;
                            n_state = S_FINISH;
                        end else begin
                            dp_cmd.op = OP_INS_INIT;
                            n_state   = S_INS;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                dp_cmd.op = OP_SCAN;
                if (i_dp_sts.hit) begin
                    if (i_dp_sts.cmd == CMD_SEARCH) begin
                        n_found = 1'b1;
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_DEL_INIT;
                    end
                end else if (i_dp_sts.fwd_done) begin
                    n_res   = ST_NOTFOUND;
                    n_state = S_FINISH;
                end
            end
            S_DEL_INIT: begin
                dp_cmd.op = OP_DEL_INIT;
                n_state   = S_DEL;
            end
            S_DEL: begin
                dp_cmd.op = OP_DEL;
                if (i_dp_sts.fwd_done) begin
                    n_state = S_FINISH;
                end
            end
            S_INS: begin
                dp_cmd.op = OP_INS;
                if (i_dp_sts.rev_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                dp_cmd.op = OP_PUT;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (i_dp_sts.out_free) begin
                    dp_cmd.op = OP_RESULT;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= ST_OK;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            r_found <= n_found;
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_dp_cmd = dp_cmd;

endmodule

// File: sv/kal_dp.sv
module kal_dp #(
    parameter int DEPTH = kal_pkg::DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kal_pkg::t_dp_cmd                i_dp_cmd,
    output kal_pkg::t_dp_sts                o_dp_sts,
    input  logic [kal_pkg::CMD_W-1:0]       i_cmd,
    input  logic signed [kal_pkg::KEY_W-1:0] i_key,
    input  logic [kal_pkg::PAY_W-1:0]       i_payload,
    input  logic [kal_pkg::POS_W-1:0]       i_position,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [kal_pkg::STATUS_W-1:0]    o_status,
    output logic [kal_pkg::POS_W-1:0]       o_found_position,
    output logic [kal_pkg::PAY_W-1:0]       o_found_payload,
    output logic [kal_pkg::CNT_OUT_W-1:0]   o_entry_count
);
    import kal_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // entry storage
    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [PAY_W-1:0] pay_mem [DEPTH];

    // latched item
    logic [CMD_W-1:0] r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_pay;
    logic [POS_W-1:0] r_pos;

    // walk and list state
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic [CW-1:0]    r_cmp_idx, n_cmp_idx;
    logic             r_rd_vld, n_rd_vld;
    logic [CW-1:0]    r_wr_idx, n_wr_idx;
    logic [CW-1:0]    r_ins_idx, n_ins_idx;
    logic [CW-1:0]    r_hit_idx, n_hit_idx;
    logic [PAY_W-1:0] r_hit_pay, n_hit_pay;
    logic [KEY_W-1:0] r_rd_key;
    logic [PAY_W-1:0] r_rd_pay;

    // result register
    logic                 r_o_valid, n_o_valid;
    logic [STATUS_W-1:0]  r_o_status;
    logic [POS_W-1:0]     r_o_fpos;
    logic [PAY_W-1:0]     r_o_fpay;
    logic [CNT_OUT_W-1:0] r_o_cnt;

    // memory port controls
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [PAY_W-1:0] wr_pay;

    logic          hit;
    logic          fwd_done;
    logic          rev_done;
    logic          out_free;
    logic [CW-1:0] rd_prev;
    logic [PW-1:0] pos_w;
    logic [PW-1:0] pos_m1;
    logic [PW-1:0] fpos_w;
    logic [PW-1:0] cnt_w;

    // status toward the controller
    assign hit      = r_rd_vld && (r_rd_key == r_key);
    assign fwd_done = !r_rd_vld && (r_rd_idx >= r_count);
    assign rev_done = !r_rd_vld && (r_rd_idx <= r_ins_idx);
    assign out_free = !r_o_valid || !i_stall;
    assign pos_w    = PW'(r_pos);
    assign pos_m1   = pos_w - PW'(1);
    assign rd_prev  = r_rd_idx - CW'(1);

    always_comb begin
        o_dp_sts.cmd      = r_cmd;
        o_dp_sts.full     = (r_count == DEPTH_C);
        o_dp_sts.empty    = (r_count == '0);
        o_dp_sts.bad_pos  = (pos_w == '0) || (pos_w > (PW'(r_count) + PW'(1)));
        o_dp_sts.hit      = hit;
        o_dp_sts.fwd_done = fwd_done;
        o_dp_sts.rev_done = rev_done;
        o_dp_sts.out_free = out_free;
    end

    // walk pointers and memory port selection
    always_comb begin
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_cmp_idx = r_cmp_idx;
        n_rd_vld  = r_rd_vld;
        n_wr_idx  = r_wr_idx;
        n_ins_idx = r_ins_idx;
        n_hit_idx = r_hit_idx;
        n_hit_pay = r_hit_pay;
        rd_en     = 1'b0;
        rd_addr   = r_rd_idx[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_wr_idx[AW-1:0];
        wr_key    = r_rd_key;
        wr_pay    = r_rd_pay;
        case (i_dp_cmd.op)
            OP_APPEND: begin
                wr_en   = 1'b1;
                wr_addr = r_count[AW-1:0];
                wr_key  = r_key;
                wr_pay  = r_pay;
                n_count = r_count + CW'(1);
            end
            OP_SCAN_INIT: begin
                n_rd_idx = '0;
                n_rd_vld = 1'b0;
            end
            OP_SCAN: begin
                // read one entry ahead, compare the one read last cycle
                if (r_rd_idx < r_count) begin
                    rd_en     = 1'b1;
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_cmp_idx = r_rd_idx;
                    n_rd_vld  = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (hit) begin
                    n_hit_idx = r_cmp_idx;
                    n_hit_pay = r_rd_pay;
                end
            end
            OP_DEL_INIT: begin
                n_rd_idx = r_hit_idx + CW'(1);
                n_wr_idx = r_hit_idx;
                n_rd_vld = 1'b0;
            end
            OP_DEL: begin
                // move entries behind the hole down by one
                if (r_rd_idx < r_count) begin
                    rd_en    = 1'b1;
                    n_rd_idx = r_rd_idx + CW'(1);
                    n_rd_vld = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld) begin
                    wr_en    = 1'b1;
                    n_wr_idx = r_wr_idx + CW'(1);
                end
                if (fwd_done) begin
                    n_count = r_count - CW'(1);
                end
            end
            OP_INS_INIT: begin
                n_rd_idx  = r_count;
                n_wr_idx  = r_count;
                n_rd_vld  = 1'b0;
                n_ins_idx = pos_m1[CW-1:0];
            end
            OP_INS: begin
                // move entries from the tail up by one, down to the slot
                if (r_rd_idx > r_ins_idx) begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_prev[AW-1:0];
                    n_rd_idx = rd_prev;
                    n_rd_vld = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld) begin
                    wr_en    = 1'b1;
                    n_wr_idx = r_wr_idx - CW'(1);
                end
            end
            OP_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_ins_idx[AW-1:0];
                wr_key  = r_key;
                wr_pay  = r_pay;
                n_count = r_count + CW'(1);
            end
            default: begin
            end
        endcase
    end

    // entry memories, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            pay_mem[wr_addr] <= wr_pay;
        end
        if (rd_en) begin
            r_rd_key <= key_mem[rd_addr];
            r_rd_pay <= pay_mem[rd_addr];
        end
    end

    // result fields
    assign fpos_w = PW'(r_hit_idx) + PW'(1);
    assign cnt_w  = PW'(r_count);

    always_comb begin
        if (i_dp_cmd.op == OP_RESULT) begin
            n_o_valid = 1'b1;
        end else if (!i_stall) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_cmp_idx <= '0;
            r_rd_vld  <= 1'b0;
            r_wr_idx  <= '0;
            r_ins_idx <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_rd_idx  <= n_rd_idx;
            r_cmp_idx <= n_cmp_idx;
            r_rd_vld  <= n_rd_vld;
            r_wr_idx  <= n_wr_idx;
            r_ins_idx <= n_ins_idx;
            r_o_valid <= n_o_valid;
        end
    end

    // item and result payload registers
    always_ff @(posedge i_clk) begin
        r_hit_idx <= n_hit_idx;
        r_hit_pay <= n_hit_pay;
        if (i_dp_cmd.op == OP_LOAD) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
            r_pay <= i_payload;
            r_pos <= i_position;
        end
        if (i_dp_cmd.op == OP_RESULT) begin
            r_o_status <= i_dp_cmd.res_status;
            r_o_fpos   <= i_dp_cmd.res_found ? fpos_w[POS_W-1:0] : '0;
            r_o_fpay   <= i_dp_cmd.res_found ? r_hit_pay : '0;
            r_o_cnt    <= cnt_w[CNT_OUT_W-1:0];
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_found_position = r_o_fpos;
    assign o_found_payload  = r_o_fpay;
    assign o_entry_count    = r_o_cnt;

endmodule

// File: sv/keyed_array_list.sv
// accepted items are latched and dispatched: append, and any full, empty or bad
// position outcome, go straight to the result; search walks the entries from the head
// to the first match; a search or delete miss walks all n stored entries; delete moves
// the entries behind the match down by one; insert moves entries from the tail up by
// one down to the slot, then writes the item. one item at a time: the input stalls
// until the result is loaded. synchronous active-low reset clears list and result
module keyed_array_list #(
    parameter int DEPTH = kal_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [kal_pkg::CMD_W-1:0]        i_cmd,
    input  logic signed [kal_pkg::KEY_W-1:0] i_key,
    input  logic [kal_pkg::PAY_W-1:0]        i_payload,
    input  logic [kal_pkg::POS_W-1:0]        i_position,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [kal_pkg::STATUS_W-1:0]     o_status,
    output logic [kal_pkg::POS_W-1:0]        o_found_position,
    output logic [kal_pkg::PAY_W-1:0]        o_found_payload,
    output logic [kal_pkg::CNT_OUT_W-1:0]    o_entry_count
);
    import kal_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // command sequencer
    kal_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_dp_cmd (dp_cmd),
        .i_dp_sts (dp_sts)
    );

    // storage, walk pointers and result register
    kal_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dp_cmd         (dp_cmd),
        .o_dp_sts         (dp_sts),
        .i_cmd            (i_cmd),
        .i_key            (i_key),
        .i_payload        (i_payload),
        .i_position       (i_position),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_found_payload  (o_found_payload),
        .o_entry_count    (o_entry_count)
    );

endmodule

// File: sv/kal_chk.sv
module kal_chk #(
    parameter int DEPTH = kal_pkg::DEPTH_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic [kal_pkg::CMD_W-1:0]        i_cmd,
    input logic signed [kal_pkg::KEY_W-1:0] i_key,
    input logic [kal_pkg::PAY_W-1:0]        i_payload,
    input logic [kal_pkg::POS_W-1:0]        i_position,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [kal_pkg::STATUS_W-1:0]     o_status,
    input logic [kal_pkg::POS_W-1:0]        o_found_position,
    input logic [kal_pkg::PAY_W-1:0]        o_found_payload,
    input logic [kal_pkg::CNT_OUT_W-1:0]    o_entry_count
);
    import kal_pkg::*;

    // a stalled input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_cmd) && $stable(i_key)
            && $stable(i_payload) && $stable(i_position)))
        else $error("input item changed while stalled");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status)
            && $stable(o_found_position) && $stable(o_found_payload)
            && $stable(o_entry_count)))
        else $error("result changed while stalled");

    // only a successful item carries match data
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> ((o_found_position == '0)
            && (o_found_payload == '0)))
        else $error("match data on a failed item");

    // empty status only with no entries
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EMPTY)) |-> (o_entry_count == '0))
        else $error("empty status with entries stored");

    // full status only at capacity
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_entry_count == CNT_OUT_W'(DEPTH)))
        else $error("full status below capacity");

endmodule

bind keyed_array_list kal_chk #(
    .DEPTH (DEPTH)
) u_kal_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .i_cmd            (i_cmd),
    .i_key            (i_key),
    .i_payload        (i_payload),
    .i_position       (i_position),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_status         (o_status),
    .o_found_position (o_found_position),
    .o_found_payload  (o_found_payload),
    .o_entry_count    (o_entry_count)
);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import kal_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 900;
    localparam int BATCH        = 8;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE       = 300;
    localparam int HOLD_EVERY   = 300;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        logic [POS_W-1:0] pos;
    } list_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [POS_W-1:0]     hit_pos;
        logic [PAY_W-1:0]     hit_pay;
        logic [CNT_OUT_W-1:0] len;
    } list_result_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [CMD_W-1:0]          i_cmd = '0;
    logic signed [KEY_W-1:0]   i_key = '0;
    logic [PAY_W-1:0]          i_payload = '0;
    logic [POS_W-1:0]          i_position = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [STATUS_W-1:0]       o_status;
    logic [POS_W-1:0]          o_found_position;
    logic [PAY_W-1:0]          o_found_payload;
    logic [CNT_OUT_W-1:0]      o_entry_count;

    keyed_array_list #(.DEPTH(LIST_DEPTH)) i_dut (.*);

    // shadow copy of the list contents
    logic [KEY_W-1:0] shadow_keys [LIST_DEPTH];
    logic [PAY_W-1:0] shadow_pays [LIST_DEPTH];
    int               shadow_len = 0;

    list_cmd_t    cmd_queue [$];
    list_result_t awaited_results [$];
    list_result_t got_res;
    list_result_t want_res;

    int err_cnt       = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int results_taken = 0;
    int quiet_cycles  = 0;
    bit tx_quiet      = 1'b0;
    bit rx_quiet      = 1'b0;

    logic [KEY_W-1:0] key_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
                                       32'h8000_0000, 32'h7fff_ffff, 32'h5a5a_5a5a,
                                       32'ha5a5_a5a5, 32'h1234_5678};

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // apply one command to the shadow list and return the result it gives
    function automatic list_result_t apply_list_cmd(input list_cmd_t c);
        list_result_t r;
        int hit;
        int p;
        r = '0;
        hit = -1;
        p = int'(c.pos);
        if (c.cmd == CMD_SEARCH || c.cmd == CMD_DELETE) begin
            for (int i = shadow_len - 1; i >= 0; i--) begin
                if (shadow_keys[i] == c.key) hit = i;
            end
        end
        case (c.cmd)
            CMD_APPEND: begin
                if (shadow_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_keys[shadow_len] = c.key;
                    shadow_pays[shadow_len] = c.pay;
                    shadow_len++;
                end
            end
            CMD_SEARCH: begin
                if (shadow_len == 0) r.status = ST_EMPTY;
                else if (hit < 0) r.status = ST_NOTFOUND;
                else begin
                    r.hit_pos = POS_W'(hit + 1);
                    r.hit_pay = shadow_pays[hit];
                end
            end
            CMD_DELETE: begin
                if (shadow_len == 0) r.status = ST_EMPTY;
                else if (hit < 0) r.status = ST_NOTFOUND;
                else begin
                    for (int i = hit; i + 1 < shadow_len; i++) begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_pays[i] = shadow_pays[i+1];
                    end
                    shadow_len--;
                end
            end
            default: begin
                // insert: fullness is checked before the position
                if (shadow_len >= LIST_DEPTH) r.status = ST_FULL;
                else if (p < 1 || p > shadow_len + 1) r.status = ST_BADPOS;
                else begin
                    for (int i = shadow_len; i >= p; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_pays[i] = shadow_pays[i-1];
                    end
                    shadow_keys[p-1] = c.key;
                    shadow_pays[p-1] = c.pay;
                    shadow_len++;
                end
            end
        endcase
        r.len = shadow_len[CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [PAY_W-1:0] pay, input logic [POS_W-1:0] pos);
        cmd_queue.push_back('{cmd, key, pay, pos});
    endtask

    // a stored key, a key from the small pool (duplicates) or any key
    function automatic logic [KEY_W-1:0] pick_key(input bit stored);
        if (stored && shadow_len > 0) return shadow_keys[$urandom_range(shadow_len - 1)];
        if ($urandom_range(1) == 0) return key_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // one random item, biased toward growing or shrinking the list
    task automatic queue_random(input bit grow);
        list_cmd_t c;
        int r;
        r = $urandom_range(99);
        c.key = pick_key(1'b0);
        c.pay = $urandom;
        c.pos = POS_W'($urandom_range(255));
        if (grow) begin
            if (r < 50) c.cmd = CMD_APPEND;
            else if (r < 80) c.cmd = CMD_INSERT;
            else if (r < 92) begin
                c.cmd = CMD_SEARCH;
                c.key = pick_key(1'b1);
            end else if (r < 95) c.cmd = CMD_DELETE;
            else c.cmd = CMD_W'($urandom_range(3));
        end else begin
            if (r < 50) begin
                c.cmd = CMD_DELETE;
                c.key = pick_key(1'b1);
            end else if (r < 65) c.cmd = CMD_DELETE;
            else if (r < 82) begin
                c.cmd = CMD_SEARCH;
                c.key = pick_key(1'($urandom_range(1)));
            end else if (r < 90) c.cmd = CMD_INSERT;
            else if (r < 95) c.cmd = CMD_APPEND;
            else c.cmd = CMD_W'($urandom_range(3));
        end
        // mostly legal insert positions
        if (c.cmd == CMD_INSERT && r < 95 && $urandom_range(9) < 8)
            c.pos = POS_W'($urandom_range(shadow_len + 1, 1));
        cmd_queue.push_back(c);
    endtask

    // wait until every queued item has been taken by the block
    task automatic drain_sender();
        while (cmd_queue.size() != 0 || i_valid) @(negedge i_clk);
    endtask

    // reset and stimulus
    initial begin
        int random_sent;
        int brim_batches;
        bit grow;
        random_sent = 0;
        brim_batches = 0;
        grow = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, bad positions, key extremes, duplicates
        queue_cmd(CMD_SEARCH, 32'h0000_0000, 32'h0, 8'd0);
        queue_cmd(CMD_DELETE, 32'h0000_0000, 32'h0, 8'd0);
        queue_cmd(CMD_INSERT, 32'h0000_0005, 32'h1, 8'd0);
        queue_cmd(CMD_INSERT, 32'h0000_0005, 32'h1, 8'd2);
        queue_cmd(CMD_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 8'd1);
        queue_cmd(CMD_APPEND, 32'h8000_0000, 32'h0000_0000, 8'hff);
        queue_cmd(CMD_APPEND, 32'h0000_0000, 32'h5a5a_5a5a, 8'd0);
        queue_cmd(CMD_APPEND, 32'hffff_ffff, 32'ha5a5_a5a5, 8'd0);
        queue_cmd(CMD_APPEND, 32'h8000_0000, 32'h1234_5678, 8'd0);
        queue_cmd(CMD_SEARCH, 32'h8000_0000, 32'h0, 8'd0);
        queue_cmd(CMD_SEARCH, 32'h1234_5678, 32'h0, 8'd0);
        queue_cmd(CMD_INSERT, 32'h0000_0001, 32'h1111_1111, 8'd1);
        queue_cmd(CMD_INSERT, 32'h0000_0002, 32'h2222_2222, 8'd7);
        queue_cmd(CMD_INSERT, 32'h0000_0003, 32'h3333_3333, 8'd9);
        queue_cmd(CMD_INSERT, 32'h0000_0003, 32'h3333_3333, 8'd255);
        queue_cmd(CMD_INSERT, 32'hffff_fffe, 32'h4444_4444, 8'd4);
        queue_cmd(CMD_DELETE, 32'h8000_0000, 32'h0, 8'd0);
        queue_cmd(CMD_SEARCH, 32'h8000_0000, 32'h0, 8'd0);
        queue_cmd(CMD_DELETE, 32'h0000_0002, 32'h0, 8'd0);
        queue_cmd(CMD_DELETE, 32'h0000_0001, 32'h0, 8'd0);
        queue_cmd(CMD_DELETE, 32'h1234_5678, 32'h0, 8'd0);
        queue_cmd(CMD_SEARCH, 32'h7fff_ffff, 32'h0, 8'd0);
        queue_cmd(CMD_SEARCH, 32'hffff_fffe, 32'h0, 8'd0);
        drain_sender();

        // random: fill to full, dwell there, drain to empty, dwell, repeat
        while (random_sent < RANDOM_ITEMS) begin
            if (grow && shadow_len == LIST_DEPTH) brim_batches++;
            if (!grow && shadow_len == 0) brim_batches++;
            if (brim_batches >= 2) begin
                grow = !grow;
                brim_batches = 0;
            end
            repeat (BATCH) queue_random(grow);
            random_sent += BATCH;
            drain_sender();
        end

        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (err_cnt == 0 && awaited_results.size() == 0) begin
            $display("keyed_array_list verification clean");
        end else begin
            $display("keyed_array_list verification failed");
        end
        $finish;
    end

    // sender: offer queued items with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                awaited_results.push_back(
                    apply_list_cmd('{i_cmd, i_key, i_payload, i_position}));
                if ($urandom_range(39) == 0) tx_quiet = !tx_quiet;
                gap_left = tx_quiet ? 0 : $urandom_range(19);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    {i_cmd, i_key, i_payload, i_position} <= cmd_queue.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, a long hold now and then, result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                got_res = '{o_status, o_found_position, o_found_payload, o_entry_count};
                if (awaited_results.size() == 0) begin
                    if (err_cnt < 10)
                        $display("%0t unexpected item: status %0d pos %0d payload %h count %0d",
                                 $realtime, got_res.status, got_res.hit_pos, got_res.hit_pay,
                                 got_res.len);
                    err_cnt++;
                end else begin
                    want_res = awaited_results.pop_front();
                    if (got_res.status !== want_res.status ||
                        got_res.hit_pos !== want_res.hit_pos ||
                        got_res.hit_pay !== want_res.hit_pay ||
                        got_res.len !== want_res.len) begin
                        if (err_cnt < 10)
                            $display(
                                "%0t mismatch exp/act st %0d/%0d pos %0d/%0d pay %h/%h cnt %0d/%0d",
                                $realtime, want_res.status, got_res.status,
                                want_res.hit_pos, got_res.hit_pos,
                                want_res.hit_pay, got_res.hit_pay,
                                want_res.len, got_res.len);
                        err_cnt++;
                    end
                end
                results_taken++;
                if (results_taken % HOLD_EVERY == 0) begin
                    stall_left = HOLD_CYCLES;
                end else begin
                    if ($urandom_range(39) == 0) rx_quiet = !rx_quiet;
                    stall_left = rx_quiet ? 0 : $urandom_range(19);
                end
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_stall <= (stall_left > 0);
        end
    end

    // watchdog: no item moving on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("keyed_array_list verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// File: filelist.f
sv/kal_pkg.sv
sv/kal_ctrl.sv
sv/kal_dp.sv
sv/keyed_array_list.sv
sv/kal_chk.sv
verif/tb.sv
